>>> sv/cdad_pkg.sv
// cdad_pkg: shared constants, status codes and the month-length table
// for the calendar date adder; no dependencies
package cdad_pkg;

    // default sizes of the stored year and the day counter
    localparam int YEAR_BITS_DEF = 14;
    localparam int ADD_BITS_DEF  = 16;

    // widths of the request and result fields
    localparam int LOAD_YEAR_BITS = 14;
    localparam int MONTH_BITS     = 4;
    localparam int DAY_BITS       = 5;
    localparam int DAYS_IN_BITS   = 16;
    localparam int STATUS_BITS    = 2;
    localparam int S_TDATA_BITS   = 40;
    localparam int M_TDATA_BITS   = 32;

    // divisor used for the century part of the leap rule
    localparam int LEAP_DIV  = 25;
    localparam int REM_BITS  = 5;

    // request kinds carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_ADD  = 1'b1;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_LOAD = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

    // calendar constants
    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_BITS-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_BITS-1:0]   DAY_LAST  = 5'd31;
    localparam logic [DAY_BITS-1:0]   FEB_LEAP  = 5'd29;

    localparam logic [DAY_BITS-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // leap year from the low year bits and the year modulo 25:
    // divisible by 4, and not by 100 unless also by 400
    function automatic logic is_leap(input logic [3:0] year_lo,
                                     input logic [REM_BITS-1:0] rem25);
        logic by4;
        logic by16;
        by4  = (year_lo[1:0] == 2'b00);
        by16 = (year_lo == 4'b0000);
        return by4 && ((rem25 != '0) || by16);
    endfunction

    // days in a month; zero for a month code outside 1 to 12
    function automatic logic [DAY_BITS-1:0] month_length(
        input logic [MONTH_BITS-1:0] month,
        input logic                  leap);
        logic [DAY_BITS-1:0] len;
        len = '0;
        if (month == MONTH_FEB && leap)
        begin
            len = FEB_LEAP;
        end
        else if (month >= MONTH_JAN && month <= MONTH_DEC)
        begin
            len = MONTH_LEN[month - 4'd1];
        end
        return len;
    endfunction

endpackage

>>> sv/cdad_mod25.sv
// cdad_mod25: remainder of a loaded year modulo 25 by reciprocal multiplication,
// quotient registered first, then the remainder; depends on cdad_pkg
module cdad_mod25
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [cdad_pkg::LOAD_YEAR_BITS-1:0]  value,
    output logic                                 busy,
    output logic [cdad_pkg::REM_BITS-1:0]        rem
);

    localparam int YB        = cdad_pkg::LOAD_YEAR_BITS;
    localparam int RB        = cdad_pkg::REM_BITS;
    // 2^19 / 25 rounded up gives the exact quotient for every 14-bit year
    localparam int REC_SHIFT = 19;
    localparam int REC_BITS  = 15;
    localparam int QUO_BITS  = 10;
    localparam int PROD_W    = YB + REC_BITS;
    localparam logic [REC_BITS-1:0] REC_MUL = 15'd20972;

    logic                busy_reg, busy_next;
    logic [YB-1:0]       val_reg, val_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [RB-1:0]       rem_reg, rem_next;
    logic [PROD_W-1:0]   product;
    logic [YB-1:0]       quo_times_div;

    // quotient by the reciprocal, then back-multiplied by 25
    assign product       = PROD_W'(value) * PROD_W'(REC_MUL);
    assign quo_times_div = YB'(quo_reg) * YB'(cdad_pkg::LEAP_DIV);

    // on start the quotient is taken, then while busy the remainder is formed
    always_comb
    begin
        busy_next = 1'b0;
        val_next  = val_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            val_next  = value;
            quo_next  = product[REC_SHIFT+QUO_BITS-1:REC_SHIFT];
        end
        else if (busy_reg)
        begin
            rem_next = RB'(val_reg - quo_times_div);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/calendar_date_add_days.sv
// calendar_date_add_days: keeps a Gregorian date, loads it or advances it
// by a day count one month per cycle; depends on cdad_pkg and cdad_mod25
//
//  channel  dir  tdata (low bit up)                         tuser
//  s_*      in   new_year, new_month, new_day, days_to_add  action
//  m_*      out  out_year, out_month, out_day, status       -
//
// An add runs the shared day adder and compare step once per month crossed,
// then passes the result into the output register.
// A load passes the year modulo 25 unit, then the date check and then
// the output register.
// One request is in work at a time; s_tready is high only while idle.
// The result waits in an output register until m_tready takes it.
// Reset (rst_n, asynchronous) gives 1 January 2000.
module calendar_date_add_days
#(
    parameter int YEAR_BITS = cdad_pkg::YEAR_BITS_DEF,
    parameter int ADD_BITS  = cdad_pkg::ADD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // new_year[13:0], new_month[17:14], new_day[22:18], days_to_add[38:23]
    input  logic [cdad_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // action[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_year[13:0], out_month[17:14], out_day[22:18], status[24:23]
    output logic [cdad_pkg::M_TDATA_BITS-1:0]   m_tdata
);

    localparam int YEAR_MAX = (1 << YEAR_BITS) - 1;
    localparam int CMP_W    = YEAR_BITS + cdad_pkg::LOAD_YEAR_BITS;
    localparam int LYB      = cdad_pkg::LOAD_YEAR_BITS;
    localparam int MB       = cdad_pkg::MONTH_BITS;
    localparam int DB       = cdad_pkg::DAY_BITS;
    localparam int SB       = cdad_pkg::STATUS_BITS;

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_MOD   = 5'b00010,
        S_CHECK = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [YEAR_BITS-1:0]          cur_year_reg, cur_year_next;
    logic [MB-1:0]                 cur_month_reg, cur_month_next;
    logic [DB-1:0]                 cur_day_reg, cur_day_next;
    logic [cdad_pkg::REM_BITS-1:0] cur_rem_reg, cur_rem_next;
    logic [SB-1:0]                 status_reg, status_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [cdad_pkg::M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic [LYB-1:0]      ld_year_reg, ld_year_next;
    logic [MB-1:0]       ld_month_reg, ld_month_next;
    logic [DB-1:0]       ld_day_reg, ld_day_next;
    logic [ADD_BITS-1:0] inc_reg, inc_next;

    logic                          accept;
    logic                          mod_busy;
    logic [cdad_pkg::REM_BITS-1:0] mod_rem;
    logic                          sel_load;
    logic [MB-1:0]                 len_month;
    logic                          len_leap;
    logic [DB-1:0]                 len;
    logic [ADD_BITS:0]             sum;
    logic [DB:0]                   step;
    logic                          load_ok;
    logic                          out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // year modulo 25 for a load
    cdad_mod25 u_mod25
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (s_tuser == cdad_pkg::ACT_LOAD)),
        .value (s_tdata[LYB-1:0]),
        .busy  (mod_busy),
        .rem   (mod_rem)
    );

    // shared month-length lookup: loaded date while checking, else stored date
    assign sel_load  = (state_reg == S_CHECK);
    assign len_month = sel_load ? ld_month_reg : cur_month_reg;
    assign len_leap  = sel_load ? cdad_pkg::is_leap(ld_year_reg[3:0], mod_rem)
                                : cdad_pkg::is_leap(cur_year_reg[3:0], cur_rem_reg);
    assign len       = cdad_pkg::month_length(len_month, len_leap);

    // shared day adder and the days left in the month
    assign sum  = (ADD_BITS+1)'(inc_reg) + (ADD_BITS+1)'(cur_day_reg);
    assign step = (DB+1)'(len) - (DB+1)'(cur_day_reg) + (DB+1)'(1);

    assign load_ok = (CMP_W'(ld_year_reg) <= CMP_W'(YEAR_MAX))
                  && (ld_day_reg != '0) && (ld_day_reg <= len);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        cur_rem_next   = cur_rem_reg;
        status_next    = status_reg;
        ld_year_next   = ld_year_reg;
        ld_month_next  = ld_month_reg;
        ld_day_next    = ld_day_reg;
        inc_next       = inc_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ld_year_next  = s_tdata[LYB-1:0];
                    ld_month_next = s_tdata[LYB+MB-1:LYB];
                    ld_day_next   = s_tdata[LYB+MB+DB-1:LYB+MB];
                    inc_next      = ADD_BITS'({{ADD_BITS{1'b0}},
                        s_tdata[LYB+MB+DB+cdad_pkg::DAYS_IN_BITS-1:LYB+MB+DB]});
                    status_next   = cdad_pkg::ST_OK;
                    state_next    = (s_tuser == cdad_pkg::ACT_LOAD) ? S_MOD : S_ADD;
                end
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // an invalid month gives length zero and fails the day test
                if (load_ok)
                begin
                    cur_year_next  = YEAR_BITS'({{YEAR_BITS{1'b0}}, ld_year_reg});
                    cur_month_next = ld_month_reg;
                    cur_day_next   = ld_day_reg;
                    cur_rem_next   = mod_rem;
                end
                else
                begin
                    status_next = cdad_pkg::ST_BAD_LOAD;
                end
                state_next = S_OUT;
            end
            S_ADD:
            begin
                if (sum <= (ADD_BITS+1)'(len))
                begin
                    cur_day_next = DB'(sum);
                    state_next   = S_OUT;
                end
                else
                begin
                    inc_next     = inc_reg - ADD_BITS'(step);
                    cur_day_next = cdad_pkg::DAY_FIRST;
                    if (cur_month_reg >= cdad_pkg::MONTH_DEC)
                    begin
                        if (&cur_year_reg)
                        begin
                            // saturate at the last day of the largest year
                            cur_month_next = cdad_pkg::MONTH_DEC;
                            cur_day_next   = cdad_pkg::DAY_LAST;
                            status_next    = cdad_pkg::ST_OVERFLOW;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            cur_year_next  = cur_year_reg + YEAR_BITS'(1);
                            cur_month_next = cdad_pkg::MONTH_JAN;
                            cur_rem_next   = (cur_rem_reg ==
                                cdad_pkg::REM_BITS'(cdad_pkg::LEAP_DIV - 1))
                                ? '0 : cur_rem_reg + cdad_pkg::REM_BITS'(1);
                        end
                    end
                    else
                    begin
                        cur_month_next = cur_month_reg + MB'(1);
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = cdad_pkg::M_TDATA_BITS'({status_reg, cur_day_reg,
                                    cur_month_reg,
                                    LYB'({{LYB{1'b0}}, cur_year_reg})});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_year_reg  <= YEAR_BITS'(2000);
            cur_month_reg <= cdad_pkg::MONTH_JAN;
            cur_day_reg   <= cdad_pkg::DAY_FIRST;
            cur_rem_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_year_reg  <= cur_year_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            cur_rem_reg   <= cur_rem_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        ld_year_reg  <= ld_year_next;
        ld_month_reg <= ld_month_next;
        ld_day_reg   <= ld_day_next;
        inc_reg      <= inc_next;
        status_reg   <= status_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // stored date stays a real date
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_month_reg >= cdad_pkg::MONTH_JAN) && (cur_month_reg <= cdad_pkg::MONTH_DEC)
        && (cur_day_reg != '0))
        else $error("stored date out of range");

    // year modulo 25 tracker never leaves its range
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_rem_reg < cdad_pkg::REM_BITS'(cdad_pkg::LEAP_DIV))
        else $error("year remainder out of range");

    // an accepted request closes the input until its result is out
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second request taken while busy");

    // overflow results always carry 31 December
    a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[LYB+MB+DB+SB-1:LYB+MB+DB] == cdad_pkg::ST_OVERFLOW)
        |-> (m_tdata[LYB+MB-1:LYB] == cdad_pkg::MONTH_DEC)
            && (m_tdata[LYB+MB+DB-1:LYB+MB] == cdad_pkg::DAY_LAST))
        else $error("overflow result not saturated");
`endif

endmodule

>>> test/tb_calendar_date_add_days.sv
`timescale 1ns / 100ps
// tb_calendar_date_add_days: self-checking bench for the calendar date adder;
// directed table then random load/add requests, checked against a local predictor
// depends on cdad_pkg and calendar_date_add_days
module tb_calendar_date_add_days;
    import cdad_pkg::*;

    localparam int YEAR_TOP        = (1 << YEAR_BITS_DEF) - 1;
    localparam int RANDOM_REQUESTS = 270;
    localparam int DRAIN_CYCLES    = 64;
    localparam int TIMEOUT_NS      = 50_000_000;

    typedef logic [LOAD_YEAR_BITS-1:0] year_t;
    typedef logic [MONTH_BITS-1:0]     month_t;
    typedef logic [DAY_BITS-1:0]       day_t;
    typedef logic [DAYS_IN_BITS-1:0]   count_t;
    typedef logic [STATUS_BITS-1:0]    status_t;

    typedef struct packed {
        logic   action;
        year_t  year;
        month_t month;
        day_t   day;
        count_t days;
    } day_request_t;

    // packed from the top field down: year sits in the lowest bits
    typedef struct packed {
        status_t status;
        day_t    day;
        month_t  month;
        year_t   year;
    } date_result_t;

    typedef struct packed {
        day_request_t req;
        logic         typed;
        date_result_t want;
    } step_row_t;

    // directed requests; rows with typed set carry their expected date
    localparam step_row_t STEP_TABLE [24] = '{
        '{'{ACT_ADD,  0,     0,  0,  0},     1'b1, '{ST_OK,       1,  1,  2000}},
        '{'{ACT_LOAD, 2000,  0,  15, 0},     1'b1, '{ST_BAD_LOAD, 1,  1,  2000}},
        '{'{ACT_LOAD, 2001,  15, 31, 0},     1'b1, '{ST_BAD_LOAD, 1,  1,  2000}},
        '{'{ACT_LOAD, 2001,  3,  0,  0},     1'b1, '{ST_BAD_LOAD, 1,  1,  2000}},
        '{'{ACT_LOAD, 2000,  2,  29, 0},     1'b1, '{ST_OK,       29, 2,  2000}},
        '{'{ACT_LOAD, 1900,  2,  29, 0},     1'b1, '{ST_BAD_LOAD, 29, 2,  2000}},
        '{'{ACT_LOAD, 2023,  2,  29, 0},     1'b1, '{ST_BAD_LOAD, 29, 2,  2000}},
        '{'{ACT_LOAD, 2023,  4,  31, 0},     1'b1, '{ST_BAD_LOAD, 29, 2,  2000}},
        '{'{ACT_LOAD, 2024,  2,  29, 65535}, 1'b1, '{ST_OK,       29, 2,  2024}},
        '{'{ACT_ADD,  16383, 15, 31, 1},     1'b0, '0},
        '{'{ACT_LOAD, 1899,  12, 31, 0},     1'b1, '{ST_OK,       31, 12, 1899}},
        '{'{ACT_ADD,  0,     0,  0,  60},    1'b0, '0},
        '{'{ACT_LOAD, 2099,  12, 31, 0},     1'b1, '{ST_OK,       31, 12, 2099}},
        '{'{ACT_ADD,  0,     0,  0,  425},   1'b0, '0},
        '{'{ACT_LOAD, 16383, 12, 31, 0},     1'b1, '{ST_OK,       31, 12, 16383}},
        '{'{ACT_ADD,  0,     0,  0,  0},     1'b1, '{ST_OK,       31, 12, 16383}},
        '{'{ACT_ADD,  0,     0,  0,  1},     1'b1, '{ST_OVERFLOW, 31, 12, 16383}},
        '{'{ACT_LOAD, 0,     1,  1,  0},     1'b1, '{ST_OK,       1,  1,  0}},
        '{'{ACT_ADD,  0,     0,  0,  65535}, 1'b0, '0},
        '{'{ACT_LOAD, 16383, 1,  1,  0},     1'b1, '{ST_OK,       1,  1,  16383}},
        '{'{ACT_ADD,  0,     0,  0,  65535}, 1'b1, '{ST_OVERFLOW, 31, 12, 16383}},
        '{'{ACT_LOAD, 16383, 12, 1,  0},     1'b1, '{ST_OK,       1,  12, 16383}},
        '{'{ACT_ADD,  0,     0,  0,  30},    1'b1, '{ST_OK,       31, 12, 16383}},
        '{'{ACT_LOAD, 16383, 2,  29, 0},     1'b1, '{ST_BAD_LOAD, 31, 12, 16383}}
    };

    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;

    // predictor copy of the stored date
    int cal_year  = 2000;
    int cal_month = 1;
    int cal_day   = 1;

    date_result_t pending_dates [$];
    int           mismatch_count = 0;
    int           sender_idle_pct = 0;
    int           sink_stall_pct  = 0;

    calendar_date_add_days DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock and a single reset at the start
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // full gregorian rule, century years only when divisible by 400
    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(int y, int m);
        if (m == 2)
        begin
            return leap_year(y) ? 29 : 28;
        end
        return MONTH_DAYS[m - 1];
    endfunction

    // apply one request to the predictor date and return the resulting date
    function automatic date_result_t advance_calendar(day_request_t r);
        date_result_t res;
        int           left;
        int           len;
        res.status = ST_OK;
        if (r.action == ACT_LOAD)
        begin
            if (r.month < MONTH_JAN || r.month > MONTH_DEC || r.day < DAY_FIRST ||
                r.day > days_in_month(r.year, r.month))
            begin
                res.status = ST_BAD_LOAD;
            end
            else
            begin
                cal_year  = r.year;
                cal_month = r.month;
                cal_day   = r.day;
            end
        end
        else
        begin
            left = r.days;
            while (1)
            begin
                len = days_in_month(cal_year, cal_month);
                if (cal_day + left <= len)
                begin
                    cal_day += left;
                    break;
                end
                left -= len - cal_day + 1;
                cal_day = 1;
                if (cal_month >= 12)
                begin
                    // saturate on the last day of the largest year
                    if (cal_year >= YEAR_TOP)
                    begin
                        cal_year   = YEAR_TOP;
                        cal_month  = 12;
                        cal_day    = 31;
                        res.status = ST_OVERFLOW;
                        break;
                    end
                    cal_year++;
                    cal_month = 1;
                end
                else
                begin
                    cal_month++;
                end
            end
        end
        res.year  = year_t'(cal_year);
        res.month = month_t'(cal_month);
        res.day   = day_t'(cal_day);
        return res;
    endfunction

    // mostly valid loads and adds, some malformed loads; unused fields random
    function automatic day_request_t random_request();
        day_request_t r;
        int           roll;
        r.year  = year_t'($urandom);
        r.month = month_t'($urandom);
        r.day   = day_t'($urandom);
        r.days  = count_t'($urandom);
        roll    = $urandom_range(99);
        if (roll < 30)
        begin
            r.action = ACT_LOAD;
            case ($urandom_range(9))
                0: r.year = year_t'($urandom_range(YEAR_TOP, YEAR_TOP - 3));
                1: r.year = year_t'(400 * $urandom_range(40));
                2: r.year = year_t'(100 * $urandom_range(163));
                3: r.year = year_t'(4 * $urandom_range(4095));
                default: ;
            endcase
            r.month = month_t'($urandom_range(12, 1));
            r.day   = day_t'($urandom_range(days_in_month(r.year, r.month), 1));
        end
        else if (roll < 40)
        begin
            r.action = ACT_LOAD;
            if ($urandom_range(1))
            begin
                r.month = month_t'($urandom_range(1) ? 0 : $urandom_range(15, 13));
            end
        end
        else
        begin
            r.action = ACT_ADD;
            roll     = $urandom_range(99);
            if (roll < 55)
            begin
                r.days = count_t'($urandom_range(40));
            end
            else if (roll < 85)
            begin
                r.days = count_t'($urandom_range(1500));
            end
            else if (roll >= 95)
            begin
                r.days = '0;
            end
        end
        return r;
    endfunction

    // offer one request, hold it until taken, then record what it should return
    task automatic send_request(input day_request_t r, input logic typed,
                                input date_result_t want);
        date_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.days, r.day, r.month, r.year};
        s_tuser  <= r.action;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = advance_calendar(r);
        pending_dates.push_back(typed ? want : predicted);
    endtask

    // stimulus, drain and verdict
    initial
    begin : stimulus
        int n;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_LOAD;
        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (STEP_TABLE[i])
        begin
            send_request(STEP_TABLE[i].req, STEP_TABLE[i].typed, STEP_TABLE[i].want);
        end
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            case ((n * 4) / RANDOM_REQUESTS)
                0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin sender_idle_pct = 66; sink_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin sender_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            send_request(random_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // result side back-pressure
    initial
    begin
        m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each returned date with the oldest outstanding one
    always @(posedge clk)
    begin
        date_result_t got;
        date_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = date_result_t'(m_tdata[$bits(date_result_t)-1:0]);
            if (pending_dates.size() == 0)
            begin
                $error("result with no request outstanding: %0d-%0d-%0d status %0d",
                       got.year, got.month, got.day, got.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("out_year", want.year, got.year);
                check_field("out_month", want.month, got.month);
                check_field("out_day", want.day, got.day);
                check_field("status", want.status, got.status);
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
